@@ sv/hcb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared constants, register indexes and types for the Hill cipher block unit.
// ----------------------------------------------------------------------------
package hcb_pkg;

  localparam int unsigned LETTER_W   = 5;
  localparam int unsigned KEY_DIM    = 4;
  localparam int unsigned KEY_W      = 5;
  localparam int unsigned ROW_W      = KEY_DIM * KEY_W;
  localparam int unsigned BSIZE_W    = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = ROW_W;
  localparam int unsigned MAX_BLOCK_DEF = 4;

  localparam logic [LETTER_W-1:0] PAD_CODE     = LETTER_W'(23);
  localparam logic [LETTER_W-1:0] LETTER_COUNT = LETTER_W'(26);
  localparam logic [BSIZE_W-1:0]  BSIZE_RESET  = BSIZE_W'(2);

  // floor(2^16 / 26): quotient estimate is at most one low for sums below 2^13
  localparam int unsigned RECIP_W     = 12;
  localparam int unsigned RECIP_SHIFT = 16;
  localparam logic [RECIP_W-1:0] RECIP_26 = RECIP_W'(2520);

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW_ZERO  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW_ONE   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW_TWO   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW_THREE = CFG_IDX_W'(4);

  localparam int unsigned Q_DEPTH = 2;

  typedef struct packed {
    logic full;
    logic valid;
  } hcb_qstat_t;

endpackage

@@ sv/hcb_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_front
// Collects letters into a block, pads with X on message end and hands each
// closed block to the block queue.
// ----------------------------------------------------------------------------
module hcb_front import hcb_pkg::*; #(
  parameter int unsigned MAX_BLOCK = MAX_BLOCK_DEF,
  parameter int unsigned CNT_W     = $clog2(MAX_BLOCK + 1),
  parameter int unsigned DW        = MAX_BLOCK * LETTER_W + CNT_W + 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [LETTER_W-1:0] letter_in_i,
  input  logic                message_end_i,
  input  logic [CNT_W-1:0]    size_i,
  input  hcb_qstat_t          qstat_i,
  output logic                push_o,
  output logic [DW-1:0]       push_data_o
);

  localparam int unsigned IDX_W = $clog2(MAX_BLOCK);

  logic [LETTER_W-1:0] buf_q [MAX_BLOCK];
  logic [CNT_W-1:0]    fill_q, fill_d;
  logic [CNT_W-1:0]    cnt;
  logic [IDX_W-1:0]    wr_idx;
  logic                accept;
  logic                close;
  logic [MAX_BLOCK*LETTER_W-1:0] blk_letters;

  assign in_stall_o = qstat_i.full;
  assign accept     = in_valid_i && !qstat_i.full;
  assign wr_idx     = fill_q[IDX_W-1:0];
  assign cnt        = fill_q + CNT_W'(1);
  assign close      = (cnt >= size_i) || message_end_i;

  always_comb begin
    for (int k = 0; k < MAX_BLOCK; k++) begin
      if (wr_idx == IDX_W'(k)) begin
        blk_letters[k*LETTER_W +: LETTER_W] = letter_in_i;
      end else if (CNT_W'(k) < cnt) begin
        blk_letters[k*LETTER_W +: LETTER_W] = buf_q[k];
      end else begin
        blk_letters[k*LETTER_W +: LETTER_W] = PAD_CODE;
      end
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (accept) begin
      fill_d = close ? '0 : cnt;
    end
  end

  assign push_o      = accept && close;
  assign push_data_o = {message_end_i, size_i, blk_letters};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      buf_q[wr_idx] <= letter_in_i;
    end
  end

endmodule

@@ sv/hcb_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_queue
// Two-entry block queue between the collecting front and the matrix back end.
// ----------------------------------------------------------------------------
module hcb_queue import hcb_pkg::*; #(
  parameter int unsigned DW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] push_data_i,
  input  logic          pop_i,
  output logic [DW-1:0] head_data_o,
  output hcb_qstat_t    qstat_o
);

  localparam int unsigned PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  logic [DW-1:0]    mem_q [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign qstat_o.full  = (count_q == CNT_W'(Q_DEPTH));
  assign qstat_o.valid = (count_q != '0);
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && qstat_o.valid;
  assign head_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ sv/hcb_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_back
// Walks the key rows of the head block, one row per cycle unless stalled:
// dot product, reciprocal quotient, remainder correction, output register.
// ----------------------------------------------------------------------------
module hcb_back import hcb_pkg::*; #(
  parameter int unsigned MAX_BLOCK = MAX_BLOCK_DEF,
  parameter int unsigned CNT_W     = $clog2(MAX_BLOCK + 1),
  parameter int unsigned DW        = MAX_BLOCK * LETTER_W + CNT_W + 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  hcb_qstat_t                   qstat_i,
  input  logic [DW-1:0]                head_data_i,
  output logic                         pop_o,
  input  logic [KEY_DIM-1:0][ROW_W-1:0] key_rows_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [LETTER_W-1:0]          letter_out_o,
  output logic                         block_last_o,
  output logic                         message_done_o
);

  localparam int unsigned IDX_W  = $clog2(MAX_BLOCK);
  localparam int unsigned PROD_W = LETTER_W + KEY_W;
  localparam int unsigned SUM_W  = PROD_W + $clog2(MAX_BLOCK);
  localparam int unsigned MUL_W  = SUM_W + RECIP_W;
  localparam int unsigned KCOLS  = (MAX_BLOCK < KEY_DIM) ? MAX_BLOCK : KEY_DIM;

  logic [MAX_BLOCK*LETTER_W-1:0] h_letters;
  logic [CNT_W-1:0]              h_size;
  logic                          h_done;

  logic             adv;
  logic [IDX_W-1:0] row_q, row_d;
  logic             row_last;
  logic [ROW_W-1:0] key_row;
  logic [SUM_W-1:0] dot;

  logic             s1_valid_q;
  logic [SUM_W-1:0] s1_sum_q;
  logic             s1_last_q, s1_done_q;
  logic [MUL_W-1:0] recip_prod;

  logic             s2_valid_q;
  logic [SUM_W-1:0] s2_sum_q, s2_quot_q;
  logic             s2_last_q, s2_done_q;
  logic [SUM_W-1:0] rem_raw, rem_fix;

  logic                out_valid_q;
  logic [LETTER_W-1:0] out_letter_q;
  logic                out_last_q, out_done_q;

  assign {h_done, h_size, h_letters} = head_data_i;

  assign adv      = !out_valid_q || !out_stall_i;
  assign row_last = (CNT_W'(row_q) + CNT_W'(1)) == h_size;
  assign pop_o    = adv && qstat_i.valid && row_last;

  always_comb begin
    key_row = '0;
    for (int r = 0; r < KEY_DIM; r++) begin
      if (4'(row_q) == 4'(r)) begin
        key_row = key_rows_i[r];
      end
    end
  end

  always_comb begin
    dot = '0;
    for (int k = 0; k < KCOLS; k++) begin
      if (CNT_W'(k) < h_size) begin
        dot = dot + SUM_W'(key_row[k*KEY_W +: KEY_W])
                  * SUM_W'(h_letters[k*LETTER_W +: LETTER_W]);
      end
    end
  end

  always_comb begin
    row_d = row_q;
    if (adv && qstat_i.valid) begin
      row_d = row_last ? '0 : row_q + IDX_W'(1);
    end
  end

  assign recip_prod = MUL_W'(s1_sum_q) * MUL_W'(RECIP_26);
  assign rem_raw    = s2_sum_q - SUM_W'(s2_quot_q * SUM_W'(LETTER_COUNT));
  assign rem_fix    = (rem_raw >= SUM_W'(LETTER_COUNT)) ? rem_raw - SUM_W'(LETTER_COUNT)
                                                         : rem_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      row_q <= row_d;
      if (adv) begin
        s1_valid_q  <= qstat_i.valid;
        s2_valid_q  <= s1_valid_q;
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_sum_q     <= dot;
      s1_last_q    <= row_last;
      s1_done_q    <= row_last && h_done;
      s2_sum_q     <= s1_sum_q;
      s2_quot_q    <= SUM_W'(recip_prod >> RECIP_SHIFT);
      s2_last_q    <= s1_last_q;
      s2_done_q    <= s1_done_q;
      out_letter_q <= rem_fix[LETTER_W-1:0];
      out_last_q   <= s2_last_q;
      out_done_q   <= s2_done_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign letter_out_o   = out_letter_q;
  assign block_last_o   = out_last_q;
  assign message_done_o = out_done_q;

endmodule

@@ sv/hill_cipher_block_mod26_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hill_cipher_block_mod26_unit
// Hill cipher block engine modulo 26: collects letters into blocks, pads with
// X on message end and multiplies each block by the configured key matrix.
//
//   channel | handshake                 | payload
//   --------+---------------------------+------------------------------------
//   in      | in_valid_i / in_stall_o   | letter_in_i, message_end_i
//   out     | out_valid_o / out_stall_i | letter_out_o, block_last_o,
//           |                           | message_done_o
//   cfg     | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// One letter per cycle in, one result letter per cycle out, each unless its
// channel stalls; the back end works through one key row a cycle. A closed
// block enters the queue; its rows then pass s1, s2 and the output register.
// in_stall_o rises only while the two-entry block queue is full.
// Reset clears fill count, queue and pipeline valids; block size resets to 2.
// ----------------------------------------------------------------------------
module hill_cipher_block_mod26_unit import hcb_pkg::*; #(
  parameter int unsigned MAX_BLOCK = MAX_BLOCK_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [LETTER_W-1:0]   letter_in_i,
  input  logic                  message_end_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [LETTER_W-1:0]   letter_out_o,
  output logic                  block_last_o,
  output logic                  message_done_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned CNT_W = $clog2(MAX_BLOCK + 1);
  localparam int unsigned DW    = MAX_BLOCK * LETTER_W + CNT_W + 1;

  logic [BSIZE_W-1:0]            block_size_q;
  logic [KEY_DIM-1:0][ROW_W-1:0] key_rows_q;
  logic [CNT_W-1:0]              size_eff;

  logic          push;
  logic [DW-1:0] push_data;
  logic          pop;
  logic [DW-1:0] head_data;
  hcb_qstat_t    qstat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= BSIZE_RESET;
      key_rows_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BLOCK_SIZE:    block_size_q  <= cfg_wdata_i[BSIZE_W-1:0];
        CFG_KEY_ROW_ZERO:  key_rows_q[0] <= cfg_wdata_i[ROW_W-1:0];
        CFG_KEY_ROW_ONE:   key_rows_q[1] <= cfg_wdata_i[ROW_W-1:0];
        CFG_KEY_ROW_TWO:   key_rows_q[2] <= cfg_wdata_i[ROW_W-1:0];
        CFG_KEY_ROW_THREE: key_rows_q[3] <= cfg_wdata_i[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (block_size_q < BSIZE_W'(2)) begin
      size_eff = CNT_W'(2);
    end else if (5'(block_size_q) > 5'(MAX_BLOCK)) begin
      size_eff = CNT_W'(MAX_BLOCK);
    end else begin
      size_eff = CNT_W'(block_size_q);
    end
  end

  hcb_front #(
    .MAX_BLOCK (MAX_BLOCK),
    .CNT_W     (CNT_W),
    .DW        (DW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .letter_in_i   (letter_in_i),
    .message_end_i (message_end_i),
    .size_i        (size_eff),
    .qstat_i       (qstat),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  hcb_queue #(
    .DW (DW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_data_o (head_data),
    .qstat_o     (qstat)
  );

  hcb_back #(
    .MAX_BLOCK (MAX_BLOCK),
    .CNT_W     (CNT_W),
    .DW        (DW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .qstat_i        (qstat),
    .head_data_i    (head_data),
    .pop_o          (pop),
    .key_rows_i     (key_rows_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .letter_out_o   (letter_out_o),
    .block_last_o   (block_last_o),
    .message_done_o (message_done_o)
  );

`ifndef SYNTHESIS
  a_letter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (letter_out_o < LETTER_COUNT))
    else $error("result letter not reduced modulo 26");

  a_done_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && message_done_o) |-> block_last_o)
    else $error("message end flagged off a block boundary");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !qstat.full)
    else $error("block pushed into a full queue");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> qstat.valid)
    else $error("block popped from an empty queue");
`endif

endmodule

@@ verif/tb_hill_cipher_block_mod26_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hill_cipher_block_mod26_unit
// Self-checking bench for the Hill cipher block unit. A directed table covers
// the reset state, letter and key extremes, X padding, message end on a full
// block, clamped block sizes, a block size cut mid-block and ignored register
// indexes. Random messages under varied keys and block sizes follow. Every
// output transaction is compared with a bench-side model of the modulo-26
// block product, with random stalls on both channels and one long hold-off.
// ----------------------------------------------------------------------------
module tb_hill_cipher_block_mod26_unit;
  import hcb_pkg::*;

  localparam int unsigned RAND_LETTERS = 480;
  localparam int unsigned CALM_LETTERS = 100;
  localparam int unsigned QUIET_CYCLES = 10;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned PRINT_LIMIT  = 50;

  typedef enum logic {ROW_WRITE, ROW_LETTER} row_kind_e;

  typedef struct {
    row_kind_e                 kind;
    logic [CFG_IDX_W-1:0]      idx;
    logic [CFG_DATA_W-1:0]     data;
    logic [LETTER_W-1:0]       letter;
    logic                      msg_end;
    bit                        typed;
    logic [4*LETTER_W-1:0]     typed_out;
  } stim_row_t;

  typedef struct {
    logic [LETTER_W-1:0] letter;
    logic                last;
    logic                done;
  } cipher_res_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [LETTER_W-1:0]   letter_in_i = '0;
  logic                  message_end_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [LETTER_W-1:0]   letter_out_o;
  logic                  block_last_o;
  logic                  message_done_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  // bench copy of the block state and registers
  logic [BSIZE_W-1:0]  mdl_bsize;
  logic [ROW_W-1:0]    mdl_key [KEY_DIM];
  logic [LETTER_W-1:0] mdl_buf [MAX_BLOCK_DEF];
  int unsigned         mdl_fill;

  cipher_res_t  pending_letters [$];
  stim_row_t    dir_tbl [$];
  int unsigned  mismatches = 0;
  int unsigned  cycle_cnt = 0;
  bit           calm = 1'b0;
  int unsigned  hold_asks = 0;
  int unsigned  hold_done = 0;
  int unsigned  hold_left = 0;
  int unsigned  burst_left = 0;

  hill_cipher_block_mod26_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .letter_in_i    (letter_in_i),
    .message_end_i  (message_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .letter_out_o   (letter_out_o),
    .block_last_o   (block_last_o),
    .message_done_o (message_done_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    if (mismatches < PRINT_LIMIT)
      $display("t=%0t %s: expected %0d got %0d", $time, what, want, got);
    mismatches++;
  endtask

  // Accepted letter: buffer it, close the block when full or at message end.
  task automatic encipher_letter(input logic [LETTER_W-1:0] letter, input logic msg_end,
                                 input bit typed, input logic [4*LETTER_W-1:0] typed_out);
    int unsigned n;
    int unsigned sum;
    cipher_res_t r;
    n = (mdl_bsize < 2) ? 2 : ((mdl_bsize > MAX_BLOCK_DEF) ? MAX_BLOCK_DEF : mdl_bsize);
    if (mdl_fill < MAX_BLOCK_DEF)
      mdl_buf[mdl_fill] = letter;
    mdl_fill++;
    if (mdl_fill < n && !msg_end)
      return;
    for (int i = mdl_fill; i < n; i++)
      mdl_buf[i] = PAD_CODE;
    for (int j = 0; j < n; j++) begin
      sum = 0;
      for (int k = 0; k < n; k++)
        sum += mdl_key[j][KEY_W*k +: KEY_W] * mdl_buf[k];
      r.letter = typed ? typed_out[LETTER_W*j +: LETTER_W] : LETTER_W'(sum % LETTER_COUNT);
      r.last   = (j + 1 == n);
      r.done   = (j + 1 == n) && msg_end;
      pending_letters.push_back(r);
    end
    mdl_fill = 0;
  endtask

  task automatic send_letter(input logic [LETTER_W-1:0] letter, input logic msg_end,
                             input bit typed, input logic [4*LETTER_W-1:0] typed_out);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    letter_in_i   = letter;
    message_end_i = msg_end;
    @(posedge clk_i);
    while (in_stall_o)
      @(posedge clk_i);
    encipher_letter(letter, msg_end, typed, typed_out);
  endtask

  // Sender idle until every expected letter is out, then a few quiet cycles.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_letters.size() != 0)
      @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_BLOCK_SIZE: mdl_bsize = data[BSIZE_W-1:0];
      CFG_KEY_ROW_ZERO, CFG_KEY_ROW_ONE, CFG_KEY_ROW_TWO, CFG_KEY_ROW_THREE:
        mdl_key[idx - CFG_KEY_ROW_ZERO] = data;
      default: ;
    endcase
  endtask

  function automatic stim_row_t wrow(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r.kind      = ROW_WRITE;
    r.idx       = idx;
    r.data      = data;
    r.letter    = '0;
    r.msg_end   = 1'b0;
    r.typed     = 1'b0;
    r.typed_out = '0;
    return r;
  endfunction

  function automatic stim_row_t lrow(input logic [LETTER_W-1:0] letter, input logic msg_end,
                                     input bit typed, input logic [4*LETTER_W-1:0] typed_out);
    stim_row_t r;
    r.kind      = ROW_LETTER;
    r.idx       = '0;
    r.data      = '0;
    r.letter    = letter;
    r.msg_end   = msg_end;
    r.typed     = typed;
    r.typed_out = typed_out;
    return r;
  endfunction

  // Receiver: random stall bursts, plus a long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_asks != hold_done) begin
      hold_done = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i = 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      out_stall_i = 1'b1;
    end else if (!calm && $urandom_range(0, 6) == 0) begin
      burst_left  = $urandom_range(1, 3) - 1;
      out_stall_i = 1'b1;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  always @(posedge clk_i) begin : result_check
    cipher_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_letters.size() == 0) begin
        report_mismatch("transaction with nothing expected, letter_out", 0, letter_out_o);
      end else begin
        want = pending_letters.pop_front();
        if (letter_out_o !== want.letter)
          report_mismatch("letter_out", want.letter, letter_out_o);
        if (block_last_o !== want.last)
          report_mismatch("block_last", want.last, block_last_o);
        if (message_done_o !== want.done)
          report_mismatch("message_done", want.done, message_done_o);
      end
    end
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned phase;
    int unsigned plen;
    int unsigned bsz;

    mdl_bsize = BSIZE_RESET;
    mdl_fill  = 0;
    foreach (mdl_key[i]) mdl_key[i] = '0;
    foreach (mdl_buf[i]) mdl_buf[i] = '0;

    // reset state: block size 2, zero key, so every letter comes out as A
    dir_tbl.push_back(lrow(0, 1'b0, 1'b0, '0));
    dir_tbl.push_back(lrow(25, 1'b0, 1'b1, {5'd0, 5'd0}));
    dir_tbl.push_back(lrow(31, 1'b1, 1'b1, {5'd0, 5'd0}));
    // identity key, block of four: letters pass through mod 26
    dir_tbl.push_back(wrow(CFG_BLOCK_SIZE, 20'd4));
    dir_tbl.push_back(wrow(CFG_KEY_ROW_ZERO, 20'h00001));
    dir_tbl.push_back(wrow(CFG_KEY_ROW_ONE, 20'h00020));
    dir_tbl.push_back(wrow(CFG_KEY_ROW_TWO, 20'h00400));
    dir_tbl.push_back(wrow(CFG_KEY_ROW_THREE, 20'h08000));
    dir_tbl.push_back(lrow(0, 1'b0, 1'b0, '0));
    dir_tbl.push_back(lrow(25, 1'b0, 1'b0, '0));
    dir_tbl.push_back(lrow(31, 1'b0, 1'b0, '0));
    dir_tbl.push_back(lrow(12, 1'b0, 1'b1, {5'd12, 5'd5, 5'd25, 5'd0}));
    // single letter then message end: padded with X
    dir_tbl.push_back(lrow(7, 1'b1, 1'b1, {5'd23, 5'd23, 5'd23, 5'd7}));
    // message end on a full block: no padding
    dir_tbl.push_back(lrow(1, 1'b0, 1'b0, '0));
    dir_tbl.push_back(lrow(2, 1'b0, 1'b0, '0));
    dir_tbl.push_back(lrow(3, 1'b0, 1'b0, '0));
    dir_tbl.push_back(lrow(4, 1'b1, 1'b1, {5'd4, 5'd3, 5'd2, 5'd1}));
    // all-ones key, block size above range clamps to four
    dir_tbl.push_back(wrow(CFG_KEY_ROW_ZERO, 20'hFFFFF));
    dir_tbl.push_back(wrow(CFG_KEY_ROW_ONE, 20'hFFFFF));
    dir_tbl.push_back(wrow(CFG_KEY_ROW_TWO, 20'hFFFFF));
    dir_tbl.push_back(wrow(CFG_KEY_ROW_THREE, 20'hFFFFF));
    dir_tbl.push_back(wrow(CFG_BLOCK_SIZE, 20'd7));
    dir_tbl.push_back(lrow(31, 1'b0, 1'b0, '0));
    dir_tbl.push_back(lrow(31, 1'b0, 1'b0, '0));
    dir_tbl.push_back(lrow(31, 1'b0, 1'b0, '0));
    dir_tbl.push_back(lrow(31, 1'b0, 1'b0, '0));
    // block size zero clamps to two
    dir_tbl.push_back(wrow(CFG_BLOCK_SIZE, 20'd0));
    dir_tbl.push_back(lrow(16, 1'b0, 1'b0, '0));
    dir_tbl.push_back(lrow(9, 1'b1, 1'b0, '0));
    // block size cut from four to three after three letters
    dir_tbl.push_back(wrow(CFG_BLOCK_SIZE, 20'd4));
    dir_tbl.push_back(lrow(5, 1'b0, 1'b0, '0));
    dir_tbl.push_back(lrow(6, 1'b0, 1'b0, '0));
    dir_tbl.push_back(lrow(7, 1'b0, 1'b0, '0));
    dir_tbl.push_back(wrow(CFG_BLOCK_SIZE, 20'd3));
    dir_tbl.push_back(lrow(8, 1'b0, 1'b0, '0));
    // indexes past the register list are ignored
    dir_tbl.push_back(wrow(CFG_IDX_W'(CFG_KEY_ROW_THREE + 1), 20'hFFFFF));
    dir_tbl.push_back(wrow(CFG_IDX_W'(CFG_KEY_ROW_THREE + 2), 20'hFFFFF));
    dir_tbl.push_back(wrow(CFG_IDX_W'(CFG_KEY_ROW_THREE + 3), 20'hFFFFF));
    dir_tbl.push_back(wrow(CFG_BLOCK_SIZE, 20'd1));
    dir_tbl.push_back(lrow(19, 1'b0, 1'b0, '0));
    dir_tbl.push_back(lrow(30, 1'b1, 1'b0, '0));

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].kind == ROW_WRITE) begin
        drain();
        write_reg(dir_tbl[i].idx, dir_tbl[i].data);
      end else begin
        send_letter(dir_tbl[i].letter, dir_tbl[i].msg_end, dir_tbl[i].typed,
                    dir_tbl[i].typed_out);
      end
    end

    sent  = 0;
    phase = 0;
    while (sent < RAND_LETTERS) begin
      drain();
      if (phase == 1)
        bsz = 4;
      else if (phase == 2)
        bsz = 2;
      else if ($urandom_range(0, 3) == 0)
        bsz = $urandom_range(0, 7);
      else
        bsz = $urandom_range(2, 4);
      write_reg(CFG_BLOCK_SIZE, CFG_DATA_W'(bsz));
      for (int r = 0; r < KEY_DIM; r++) begin
        if (phase == 1)
          write_reg(CFG_IDX_W'(CFG_KEY_ROW_ZERO + r), '1);
        else if (phase == 2)
          write_reg(CFG_IDX_W'(CFG_KEY_ROW_ZERO + r), '0);
        else
          write_reg(CFG_IDX_W'(CFG_KEY_ROW_ZERO + r), CFG_DATA_W'($urandom));
      end
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_IDX_W'(CFG_KEY_ROW_THREE + $urandom_range(1, 3)),
                  CFG_DATA_W'($urandom));
      plen = $urandom_range(30, 60);
      for (int i = 0; i < plen && sent < RAND_LETTERS; i++) begin
        calm = (sent >= RAND_LETTERS - CALM_LETTERS);
        if (phase == 3 && i == 8)
          hold_asks++;
        if (phase == 4 && i == 20)
          drain();
        send_letter(LETTER_W'(($urandom_range(0, 9) == 0) ? $urandom_range(26, 31)
                                                          : $urandom_range(0, 25)),
                    ($urandom_range(0, 7) == 0), 1'b0, '0);
        sent++;
      end
      phase++;
    end

    drain();
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
